[hw/rtl/top_k_value_ranker_core_assert.svh]
// Assertion macros used by the ranker top level.
`ifndef TOP_K_VALUE_RANKER_CORE_ASSERT_SVH
`define TOP_K_VALUE_RANKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TKVR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ranker assertion failed");

// Next-cycle implication, checked outside reset.
`define TKVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ranker assertion failed");

`endif

[hw/rtl/tkvr_pkg.sv]
// Types and constants shared by the ranker modules.
package tkvr_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned VALUE_W = 24;
    localparam int unsigned RANK_W  = 6;

    localparam logic [31:0] VALUE_MAX = 32'd9999999;

    typedef enum logic
    {
        ST_IDLE,
        ST_REPORT
    } state_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed
    {
        logic               ins;
        logic               pop;
        logic [VALUE_W-1:0] value;
        logic [ID_W-1:0]    id;
    } cell_ctrl_t;

endpackage

[hw/rtl/tkvr_cell.sv]
// One compare-and-shift cell of the ranking chain.
module tkvr_cell
    import tkvr_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               occ,
    input  logic               left_gt,
    input  logic [VALUE_W-1:0] left_value,
    input  logic [ID_W-1:0]    left_id,
    input  logic [VALUE_W-1:0] right_value,
    input  logic [ID_W-1:0]    right_id,
    output logic               gt,
    output logic [VALUE_W-1:0] value,
    output logic [ID_W-1:0]    id
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;

    // The list is sorted in descending order, so gt is a run of zeros
    // followed by ones; the new value lands where the ones start.
    assign gt = occ ? (ctrl.value > value_reg) : 1'b1;

    always_comb
    begin
        value_next = value_reg;
        id_next    = id_reg;
        if (ctrl.pop)
        begin
            value_next = right_value;
            id_next    = right_id;
        end
        else if (ctrl.ins && left_gt)
        begin
            value_next = left_value;
            id_next    = left_id;
        end
        else if (ctrl.ins && gt)
        begin
            value_next = ctrl.value;
            id_next    = ctrl.id;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        id_reg    <= id_next;
    end

    assign value = value_reg;
    assign id    = id_reg;

endmodule

[hw/rtl/top_k_value_ranker_core.sv]
// Top level of the ranker: controller, report sequencing and the cell chain.
//
// Channel | Direction | Handshake            | Payload
// in      | into      | in_valid / in_ready   | vehicle_id, has_record, mileage, last_vehicle
// out     | out of    | out_valid / out_ready | rank, ranked_id, ranked_value, entry_valid,
//         |           |                       | last_of_run
//
// An ordinary scan item is taken whenever in_ready is high; every cell compares and shifts at once.
// A last item is inserted in its cycle if it is valid, then the list drains from cell 0, one result
// per output transfer, with the chain shifting towards cell 0; input is held off meanwhile.
// A report of n entries thus occupies max(n, 1) output transfers.
// Reset empties the list; the cell contents themselves are not cleared.
// A stall on the output simply holds the current result and the chain.
module top_k_value_ranker_core
    import tkvr_pkg::*;
#(
    parameter int unsigned RANK_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ID_W-1:0]    vehicle_id,
    input  logic               has_record,
    input  logic [31:0]        mileage,
    input  logic               last_vehicle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [RANK_W-1:0]  rank,
    output logic [ID_W-1:0]    ranked_id,
    output logic [VALUE_W-1:0] ranked_value,
    output logic               entry_valid,
    output logic               last_of_run
);

    `include "top_k_value_ranker_core_assert.svh"

    localparam int unsigned CW = $clog2(RANK_DEPTH + 1);
    localparam int unsigned RW = $clog2(RANK_DEPTH);

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [RW-1:0]   rank_reg;
    logic [RW-1:0]   rank_next;

    logic            in_fire;
    logic            out_fire;
    logic            item_ok;
    cell_ctrl_t      ctrl;

    logic [RANK_DEPTH-1:0] gt;
    logic [VALUE_W-1:0]    cell_value [RANK_DEPTH];
    logic [ID_W-1:0]       cell_id    [RANK_DEPTH];

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign item_ok  = has_record && (mileage != 32'd0) && (mileage <= VALUE_MAX);

    assign ctrl.ins   = in_fire && item_ok;
    assign ctrl.pop   = out_fire;
    assign ctrl.value = mileage[VALUE_W-1:0];
    assign ctrl.id    = vehicle_id;

    genvar i;
    generate
        for (i = 0; i < RANK_DEPTH; i++)
        begin : g_cell
            logic               left_gt;
            logic [VALUE_W-1:0] left_value;
            logic [ID_W-1:0]    left_id;
            logic [VALUE_W-1:0] right_value;
            logic [ID_W-1:0]    right_id;

            if (i == 0)
            begin : g_head
                assign left_gt    = 1'b0;
                assign left_value = '0;
                assign left_id    = '0;
            end
            else
            begin : g_body
                assign left_gt    = gt[i-1];
                assign left_value = cell_value[i-1];
                assign left_id    = cell_id[i-1];
            end

            if (i == RANK_DEPTH - 1)
            begin : g_tail
                assign right_value = '0;
                assign right_id    = '0;
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
                assign right_id    = cell_id[i+1];
            end

            tkvr_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (count_reg > CW'(i)),
                .left_gt     (left_gt),
                .left_value  (left_value),
                .left_id     (left_id),
                .right_value (right_value),
                .right_id    (right_id),
                .gt          (gt[i]),
                .value       (cell_value[i]),
                .id          (cell_id[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rank_next    = rank_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (ctrl.ins && (count_reg < CW'(RANK_DEPTH)))
                begin
                    count_next = count_reg + CW'(1);
                end
                if (in_fire && last_vehicle)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    if (last_of_run)
                    begin
                        count_next = '0;
                        rank_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        rank_next  = rank_reg + RW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The head cell holds the current result; an empty list reports zeros.
    assign entry_valid  = (count_reg != '0);
    assign last_of_run  = (count_reg <= CW'(1));
    assign rank         = RANK_W'(rank_reg);
    assign ranked_id    = entry_valid ? cell_id[0] : '0;
    assign ranked_value = entry_valid ? cell_value[0] : '0;

    `TKVR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(RANK_DEPTH))
    `TKVR_ASSERT_NOW(a_sides_exclusive, clk, rst_n, in_ready, !out_valid)
    `TKVR_ASSERT_NEXT(a_last_starts_report, clk, rst_n, in_fire && last_vehicle, out_valid)
    `TKVR_ASSERT_NEXT(a_report_clears, clk, rst_n, out_fire && last_of_run,
                      (count_reg == '0) && in_ready && (rank_reg == '0))

endmodule
